// ===== hw/rtl/wrep_pkg.sv =====
// ----------------------------------------------------------------------------
// wrep_pkg: shared types and constants for the weighted random entry pick
// Holds the beat types of both channels, the register indexes of the
// configuration port and the sequencer state type.
// ----------------------------------------------------------------------------
package wrep_pkg;

	localparam int unsigned WeightW = 16;
	localparam int unsigned ScoreW  = 16;
	localparam int unsigned MoveW   = 16;
	localparam int unsigned RandW   = 64;
	localparam int unsigned SumW    = 32;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgW    = 16;

	// Bits of the draw counter: one step per bit of the random value.
	localparam int unsigned StepW   = $clog2(RandW);

	localparam logic [CfgIdxW-1:0] CFG_MIN_SCORE = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_PICK_BEST = 1'b1;

	typedef struct packed {
		logic        [WeightW-1:0] entry_weight;
		logic signed [ScoreW-1:0]  entry_score;
		logic        [MoveW-1:0]   entry_move;
		logic        [RandW-1:0]   random_value;
		logic                      last_entry;
	} in_beat_t;

	typedef struct packed {
		logic                      found;
		logic        [MoveW-1:0]   chosen_move;
		logic signed [ScoreW-1:0]  chosen_score;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW,
		ST_DECIDE
	} wrep_state_t;

endpackage

// ===== hw/rtl/weighted_random_entry_pick.sv =====
// ----------------------------------------------------------------------------
// weighted_random_entry_pick: weighted reservoir choice over a run of entries
// Keeps the running weight sum and the largest weight of the current run,
// draws random mod sum with a bit-serial remainder unit and holds the chosen
// entry until the last beat of the run, which releases one result beat.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                         | Carries
//  ---------+---------------------------------+----------------------------------
//  in       | in_valid, in_ready, in_data     | one candidate entry per beat
//  out      | out_valid, out_ready, out_data  | one result beat per run
//  cfg      | cfg_we, cfg_index, cfg_wdata    | min_score and pick_best writes
//
// When the running sum is non-zero an entry is taken in the idle state, then
// runs through the restoring remainder loop (one random bit per cycle through
// a single 33-bit compare and subtract) and is settled in a decision state.
// When the sum is zero the loop is skipped.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register, so a stalled out channel only holds
// the block back on a last entry that finds the register still full.
// Reset clears the run state, the configuration and the output valid flag.
//
module weighted_random_entry_pick (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  wrep_pkg::in_beat_t               in_data,

	output logic                             out_valid,
	input  logic                             out_ready,
	output wrep_pkg::out_beat_t              out_data,

	input  logic                             cfg_we,
	input  logic [wrep_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [wrep_pkg::CfgW-1:0]        cfg_wdata
);

	import wrep_pkg::*;

	// Configuration registers.
	logic signed [ScoreW-1:0]  min_score_q;
	logic                      pick_best_q;

	// Sequencer.
	wrep_state_t               state_q;
	wrep_state_t               state_d;
	logic [StepW-1:0]          step_q;

	// Run state kept across the entries of one query.
	logic [WeightW-1:0]        best_weight_q;
	logic [SumW-1:0]           weight_sum_q;
	logic [MoveW-1:0]          held_move_q;
	logic signed [ScoreW-1:0]  held_score_q;
	logic                      held_valid_q;

	// The entry being worked on.
	logic [WeightW-1:0]        weight_q;
	logic signed [ScoreW-1:0]  score_q;
	logic [MoveW-1:0]          move_q;
	logic                      last_q;
	logic                      best_hit_q;

	// Remainder unit: the random value shifts out at the top, one bit a cycle.
	logic [RandW-1:0]          dividend_q;
	logic [SumW-1:0]           rem_q;
	logic [SumW:0]             trial;
	logic                      trial_ge;
	logic [SumW-1:0]           rem_next;

	// Output register.
	logic                      out_valid_q;
	out_beat_t                 out_data_q;

	// Decision of the current entry.
	logic                      accept;
	logic                      slot_free;
	logic                      draw_hit;
	logic                      score_ok;
	logic                      take_entry;
	logic                      emit;
	logic                      step_last;
	logic [WeightW-1:0]        best_weight_new;
	logic [SumW-1:0]           weight_sum_new;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign step_last = (step_q == StepW'(RandW - 1));

	// Running maximum and wrapping sum, as they stand once this entry is added.
	assign best_weight_new = (in_data.entry_weight > best_weight_q) ?
		in_data.entry_weight : best_weight_q;
	assign weight_sum_new  = weight_sum_q + SumW'(in_data.entry_weight);

	// One restoring step: bring down the next random bit, then subtract the
	// sum if it fits. The partial remainder stays below the sum, so a single
	// subtraction always suffices and the result fits back in 32 bits.
	assign trial    = {rem_q, dividend_q[RandW-1]};
	assign trial_ge = (trial >= {1'b0, weight_sum_q});
	assign rem_next = trial_ge ? SumW'(trial - {1'b0, weight_sum_q}) : trial[SumW-1:0];

	// A zero sum never draws; the remainder is then stale and ignored.
	assign draw_hit   = (weight_sum_q != '0) && (rem_q < SumW'(weight_q));
	assign score_ok   = ($signed(score_q) >= $signed(min_score_q));
	assign take_entry = score_ok && (draw_hit || best_hit_q);

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (weight_sum_new == '0) ? ST_DECIDE : ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (step_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!last_q || slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- outputs
	always_comb begin
		in_ready = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_DRAW: begin
			end
			ST_DECIDE: begin
				emit = last_q && slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_score_q <= '0;
			pick_best_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_SCORE: min_score_q <= $signed(cfg_wdata[ScoreW-1:0]);
				CFG_PICK_BEST: pick_best_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- entry capture
	// The entry fields need no reset; they are only read after a beat is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			weight_q   <= in_data.entry_weight;
			score_q    <= in_data.entry_score;
			move_q     <= in_data.entry_move;
			last_q     <= in_data.last_entry;
			// The weight equals the new maximum exactly when it is not below the old one.
			best_hit_q <= pick_best_q && (in_data.entry_weight >= best_weight_q);
		end
	end

	// ---------------------------------------------------------------- remainder unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (accept) begin
			step_q <= '0;
		end else if (state_q == ST_DRAW) begin
			step_q <= step_q + StepW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dividend_q <= in_data.random_value;
			rem_q      <= '0;
		end else if (state_q == ST_DRAW) begin
			dividend_q <= {dividend_q[RandW-2:0], 1'b0};
			rem_q      <= rem_next;
		end
	end

	// ---------------------------------------------------------------- run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_weight_q <= '0;
			weight_sum_q  <= '0;
			held_move_q   <= '0;
			held_score_q  <= '0;
			held_valid_q  <= 1'b0;
		end else if (accept) begin
			best_weight_q <= best_weight_new;
			weight_sum_q  <= weight_sum_new;
		end else if (emit) begin
			// The run is over: start the next query from a clean slate.
			best_weight_q <= '0;
			weight_sum_q  <= '0;
			held_move_q   <= '0;
			held_score_q  <= '0;
			held_valid_q  <= 1'b0;
		end else if (state_q == ST_DECIDE && take_entry) begin
			// Repeating this while a last entry waits for the output slot
			// writes the same values again, which is harmless.
			held_move_q  <= move_q;
			held_score_q <= score_q;
			held_valid_q <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (take_entry) begin
				out_data_q.found        <= 1'b1;
				out_data_q.chosen_move  <= move_q;
				out_data_q.chosen_score <= score_q;
			end else begin
				out_data_q.found        <= held_valid_q;
				out_data_q.chosen_move  <= held_valid_q ? held_move_q : '0;
				out_data_q.chosen_score <= held_valid_q ? held_score_q : '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------------------------------------------------------- assertions
	// The remainder unit must leave a true remainder behind.
	a_rem_below_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && weight_sum_q != '0) |-> (rem_q < weight_sum_q))
		else $error("remainder not below the weight sum");

	// Releasing a result must clear the whole run state.
	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (weight_sum_q == '0 && best_weight_q == '0 && !held_valid_q))
		else $error("run state not cleared after the result");

	// A result only appears straight out of a decision cycle.
	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DECIDE))
		else $error("result raised outside a decision");

	// A result with no choice carries zero fields.
	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.found) |->
			(out_data_q.chosen_move == '0 && out_data_q.chosen_score == '0))
		else $error("empty result carries non-zero fields");

	// No new entry is taken while the remainder loop runs.
	a_no_take_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> !in_ready)
		else $error("entry taken during the draw");

endmodule
